// File: rtl/mshw_pkg.sv
// Shared types and constants of the multi-slot heartbeat watchdog.
`default_nettype none

package mshw_pkg;

    localparam int SLOT_W      = 5;
    localparam int OWNER_W     = 32;
    localparam int TICK_W      = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int MAX_RESULTS = 32;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd10000;

    typedef enum logic [1:0] {
        OP_REGISTER  = 2'd0,
        OP_HEARTBEAT = 2'd1,
        OP_RELEASE   = 2'd2,
        OP_TICK      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_GRANTED  = 2'd0,
        KIND_RELEASED = 2'd1,
        KIND_HANG     = 2'd2,
        KIND_REFUSED  = 2'd3
    } t_kind;

    typedef struct packed {
        logic accept;
        t_op  op;
        logic reg_commit;
        logic hb_commit;
        logic scan_step;
    } t_cmd;

    typedef struct packed {
        logic queue_empty;
        logic slot_ok;
        logic scan_due;
        logic scan_done;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/mshw_ctrl.sv
// Controller state machine of the multi-slot heartbeat watchdog.
`default_nettype none

module mshw_ctrl (
    input  wire                logic    i_clk,
    input  wire                logic    i_rst_n,
    input  wire                logic    i_start,
    input  wire                logic [1:0] i_operation,
    input  mshw_pkg::t_status           i_status,
    output logic                        o_busy,
    output mshw_pkg::t_cmd              o_cmd
);
    import mshw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GRANT,
        S_BEAT,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   accept;
    t_op    op;

    assign accept = i_start && !r_busy;
    assign op     = t_op'(i_operation);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_REGISTER: begin
                            if (!i_status.queue_empty) n_state = S_GRANT;
                        end
                        OP_HEARTBEAT: begin
                            if (i_status.slot_ok) n_state = S_BEAT;
                        end
                        OP_TICK: begin
                            if (i_status.scan_due) n_state = S_SCAN;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_GRANT: n_state = S_IDLE;
            S_BEAT:  n_state = S_IDLE;
            S_SCAN: begin
                if (i_status.scan_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    always_comb begin
        o_cmd.accept     = accept;
        o_cmd.op         = op;
        o_cmd.reg_commit = (r_state == S_GRANT);
        o_cmd.hb_commit  = (r_state == S_BEAT);
        o_cmd.scan_step  = (r_state == S_SCAN);
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

// File: rtl/mshw_datapath.sv
// Datapath of the multi-slot heartbeat watchdog: slot tables, free queue, tick timer, scan.
`default_nettype none

module mshw_datapath #(
    parameter int NUM_SLOTS = 32
) (
    input  wire  logic                              i_clk,
    input  wire  logic                              i_rst_n,
    input  wire  logic [mshw_pkg::SLOT_W-1:0]       i_slot,
    input  wire  logic [mshw_pkg::OWNER_W-1:0]      i_owner,
    input  wire  logic                              i_cfg_we,
    input  wire  logic [mshw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  logic [mshw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  mshw_pkg::t_cmd                          i_cmd,
    output mshw_pkg::t_status                       o_status,
    output logic                                    o_strobe,
    output logic [1:0]                              o_kind,
    output logic [mshw_pkg::SLOT_W-1:0]             o_slot_out,
    output logic [mshw_pkg::OWNER_W-1:0]            o_owner_out,
    output logic                                    o_last
);
    import mshw_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;

    // configuration
    logic              r_enable;
    logic [TICK_W-1:0] r_timeout;

    // slot tables and free queue
    logic [IW-1:0]      r_queue_mem [NUM_SLOTS];
    logic [OWNER_W-1:0] r_beat_mem  [NUM_SLOTS];
    logic [OWNER_W-1:0] r_snap_mem  [NUM_SLOTS];
    logic [OWNER_W-1:0] r_owner_mem [NUM_SLOTS];

    logic [IW-1:0]      r_q_rd;
    logic [OWNER_W-1:0] r_beat_rd;
    logic [OWNER_W-1:0] r_snap_rd;
    logic [OWNER_W-1:0] r_owner_rd;

    logic [NUM_SLOTS-1:0] r_in_use;
    logic [NUM_SLOTS-1:0] r_watched;
    logic [NUM_SLOTS-1:0] r_reported;

    logic [IW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_fill;
    logic [TICK_W-1:0] r_elapsed;

    logic [IW-1:0]      r_slot;
    logic [OWNER_W-1:0] r_new_owner;

    // scan pipeline
    logic [IW:0]        r_idx;
    logic               r_s1_v;
    logic [IW-1:0]      r_s1_idx;
    logic [RES_W-1:0]   r_nres;
    logic               r_pend_v;
    logic [IW-1:0]      r_pend_slot;
    logic [OWNER_W-1:0] r_pend_owner;

    // result register
    logic               r_out_v;
    t_kind              r_kind;
    logic [SLOT_W-1:0]  r_slot_out;
    logic [OWNER_W-1:0] r_owner_out;
    logic               r_last;

    logic [XW-1:0]     slot_wide;
    logic [IW-1:0]     slot_idx;
    logic              slot_ok;
    logic              queue_empty;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] tick_lim;
    logic              scan_due;
    logic [IW-1:0]     grant_slot;
    logic [CW:0]       tail_sum;
    logic [IW-1:0]     tail_idx;
    logic              acc_tick;
    logic              do_release;
    logic              refuse;
    logic              issue;
    logic              eval;
    logic              cand;
    logic              hang;
    logic              scan_done;
    logic [IW-1:0]     rd_addr;

    logic               beat_we;
    logic [IW-1:0]      beat_addr;
    logic [OWNER_W-1:0] beat_data;
    logic               snap_we;
    logic [IW-1:0]      snap_addr;
    logic [OWNER_W-1:0] snap_data;

    assign slot_wide   = XW'(i_slot);
    assign slot_idx    = slot_wide[IW-1:0];
    assign slot_ok     = ({1'b0, slot_wide} < (XW+1)'(NUM_SLOTS)) && r_in_use[slot_idx];
    assign queue_empty = (r_count == '0);

    assign tick_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + TICK_W'(1);
    assign tick_lim = (r_timeout == '0) ? TICK_W'(1) : r_timeout;
    assign scan_due = r_enable && (tick_inc >= tick_lim);

    assign grant_slot = (CW'(r_head) < r_fill) ? r_q_rd : r_head;
    assign tail_sum   = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign tail_idx   = (tail_sum >= (CW+1)'(NUM_SLOTS))
                        ? IW'(tail_sum - (CW+1)'(NUM_SLOTS)) : IW'(tail_sum);

    assign acc_tick   = i_cmd.accept && (i_cmd.op == OP_TICK);
    assign do_release = i_cmd.accept && (i_cmd.op == OP_RELEASE) && slot_ok;
    assign refuse     = i_cmd.accept
                        && (((i_cmd.op == OP_REGISTER) && queue_empty)
                            || (((i_cmd.op == OP_HEARTBEAT) || (i_cmd.op == OP_RELEASE))
                                && !slot_ok));

    assign issue     = i_cmd.scan_step && (r_idx < (IW+1)'(NUM_SLOTS));
    assign eval      = i_cmd.scan_step && r_s1_v && (r_nres < RES_W'(MAX_RESULTS));
    assign cand      = r_watched[r_s1_idx] && !r_reported[r_s1_idx];
    assign hang      = eval && cand && (r_beat_rd == r_snap_rd);
    assign scan_done = i_cmd.scan_step
                       && ((!r_s1_v && (r_idx == (IW+1)'(NUM_SLOTS)))
                           || (r_nres == RES_W'(MAX_RESULTS)));

    assign rd_addr = i_cmd.scan_step ? r_idx[IW-1:0] : slot_idx;

    assign beat_we   = i_cmd.reg_commit || i_cmd.hb_commit;
    assign beat_addr = i_cmd.reg_commit ? grant_slot : r_slot;
    assign beat_data = i_cmd.reg_commit ? '0 : r_beat_rd + OWNER_W'(1);
    assign snap_we   = i_cmd.reg_commit || (eval && cand);
    assign snap_addr = i_cmd.reg_commit ? grant_slot : r_s1_idx;
    assign snap_data = i_cmd.reg_commit ? '0 : r_beat_rd;

    always_ff @(posedge i_clk) begin
        if (beat_we) r_beat_mem[beat_addr] <= beat_data;
        if (snap_we) r_snap_mem[snap_addr] <= snap_data;
        if (i_cmd.reg_commit) r_owner_mem[grant_slot] <= r_new_owner;
        if (do_release) r_queue_mem[tail_idx] <= slot_idx;
        r_beat_rd  <= r_beat_mem[rd_addr];
        r_snap_rd  <= r_snap_mem[rd_addr];
        r_owner_rd <= r_owner_mem[rd_addr];
        r_q_rd     <= r_queue_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_slot      <= slot_idx;
            r_new_owner <= i_owner;
        end
        if (issue) r_s1_idx <= r_idx[IW-1:0];
        if (hang) begin
            r_pend_slot  <= r_s1_idx;
            r_pend_owner <= r_owner_rd;
        end
        if (i_cmd.reg_commit) begin
            r_kind      <= KIND_GRANTED;
            r_slot_out  <= SLOT_W'(grant_slot);
            r_owner_out <= '0;
            r_last      <= 1'b1;
        end else if (do_release) begin
            r_kind      <= KIND_RELEASED;
            r_slot_out  <= SLOT_W'(slot_idx);
            r_owner_out <= '0;
            r_last      <= 1'b1;
        end else if (refuse) begin
            r_kind      <= KIND_REFUSED;
            r_slot_out  <= '0;
            r_owner_out <= '0;
            r_last      <= 1'b1;
        end else if (r_pend_v && (hang || scan_done)) begin
            r_kind      <= KIND_HANG;
            r_slot_out  <= SLOT_W'(r_pend_slot);
            r_owner_out <= r_pend_owner;
            r_last      <= scan_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_timeout  <= TIMEOUT_RESET;
            r_in_use   <= '0;
            r_watched  <= '0;
            r_reported <= '0;
            r_head     <= '0;
            r_count    <= CW'(NUM_SLOTS);
            r_fill     <= '0;
            r_elapsed  <= '0;
            r_idx      <= '0;
            r_s1_v     <= 1'b0;
            r_nres     <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_data[TICK_W-1:0];
                    default:     r_enable  <= r_enable;
                endcase
            end

            r_out_v <= i_cmd.reg_commit || do_release || refuse
                       || (r_pend_v && (hang || scan_done));

            if (i_cmd.reg_commit) begin
                r_in_use[grant_slot]   <= 1'b1;
                r_watched[grant_slot]  <= (r_new_owner != '0);
                r_reported[grant_slot] <= 1'b0;
                r_head  <= (r_head == IW'(NUM_SLOTS - 1)) ? '0 : r_head + IW'(1);
                r_count <= r_count - CW'(1);
            end

            if (do_release) begin
                r_in_use[slot_idx]  <= 1'b0;
                r_watched[slot_idx] <= 1'b0;
                r_count <= r_count + CW'(1);
                if (r_fill != CW'(NUM_SLOTS)) r_fill <= r_fill + CW'(1);
            end

            if (acc_tick) begin
                if (!r_enable || scan_due) r_elapsed <= '0;
                else r_elapsed <= tick_inc;
                if (scan_due) begin
                    r_idx    <= '0;
                    r_s1_v   <= 1'b0;
                    r_nres   <= '0;
                    r_pend_v <= 1'b0;
                end
            end

            if (i_cmd.scan_step) begin
                r_s1_v <= issue;
                if (issue) r_idx <= r_idx + (IW+1)'(1);
                if (hang) begin
                    r_reported[r_s1_idx] <= 1'b1;
                    r_nres   <= r_nres + RES_W'(1);
                    r_pend_v <= 1'b1;
                end
                if (scan_done) r_pend_v <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.queue_empty = queue_empty;
        o_status.slot_ok     = slot_ok;
        o_status.scan_due    = scan_due;
        o_status.scan_done   = scan_done;
    end

    assign o_strobe    = r_out_v;
    assign o_kind      = r_kind;
    assign o_slot_out  = r_slot_out;
    assign o_owner_out = r_owner_out;
    assign o_last      = r_last;

endmodule

`default_nettype wire

// File: rtl/multi_slot_heartbeat_watchdog_unit.sv
// Top level of the multi-slot heartbeat watchdog.
// Register: busy while the grant commits; the grant result is registered after the S_GRANT state.
// Heartbeat: busy while the beat commits, no result. Release and refusals: result in the next cycle.
// Tick: not busy unless it starts a scan; a scan keeps busy until the walk ends or MAX_RESULTS hangs,
// a one-slot-a-cycle walk over the slot tables; hang results stream out meanwhile.
// Synchronous active-low reset: all slots free in ascending order, checking disabled.
`default_nettype none

module multi_slot_heartbeat_watchdog_unit #(
    parameter int NUM_SLOTS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        i_operation,
    input  wire logic [mshw_pkg::SLOT_W-1:0]       i_slot,
    input  wire logic [mshw_pkg::OWNER_W-1:0]      i_owner,
    input  wire logic                              i_cfg_we,
    input  wire logic [mshw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mshw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                   o_strobe,
    output logic [1:0]                             o_kind,
    output logic [mshw_pkg::SLOT_W-1:0]            o_slot_out,
    output logic [mshw_pkg::OWNER_W-1:0]           o_owner_out,
    output logic                                   o_last
);
    import mshw_pkg::*;

    t_cmd    cmd;
    t_status status;

    mshw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_status    (status),
        .o_busy      (busy),
        .o_cmd       (cmd)
    );

    mshw_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_slot      (i_slot),
        .i_owner     (i_owner),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_strobe    (o_strobe),
        .o_kind      (o_kind),
        .o_slot_out  (o_slot_out),
        .o_owner_out (o_owner_out),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench of the multi-slot heartbeat watchdog: directed and random commands.
`timescale 1ns / 1ps

module tb_top;
    import mshw_pkg::*;

    localparam int NUM_SLOTS     = 32;
    localparam int SETTLE_CYCLES = NUM_SLOTS + 4;
    localparam int STALL_LIMIT   = 1000;

    typedef struct {
        t_kind                kind;
        logic [SLOT_W-1:0]    slot;
        logic [OWNER_W-1:0]   owner;
        logic                 last;
    } t_result;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    logic [1:0]            i_operation = OP_TICK;
    logic [SLOT_W-1:0]     i_slot     = '0;
    logic [OWNER_W-1:0]    i_owner    = '0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_strobe;
    logic [1:0]            o_kind;
    logic [SLOT_W-1:0]     o_slot_out;
    logic [OWNER_W-1:0]    o_owner_out;
    logic                  o_last;

    // watchdog predictor state
    logic                  cfg_en;
    logic [TICK_W-1:0]     cfg_timeout;
    logic [SLOT_W-1:0]     free_slots [NUM_SLOTS];
    logic [SLOT_W-1:0]     free_head;
    int                    free_cnt;
    logic [31:0]           beat_cnt   [NUM_SLOTS];
    logic [31:0]           beat_snap  [NUM_SLOTS];
    logic [OWNER_W-1:0]    slot_owner [NUM_SLOTS];
    logic                  hang_seen  [NUM_SLOTS];
    logic                  slot_used  [NUM_SLOTS];
    logic [TICK_W-1:0]     elapsed;

    t_result pending_results[$];
    int      n_fail = 0;
    int      stall_cycles = 0;

    multi_slot_heartbeat_watchdog_unit #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operation(i_operation),
        .i_slot     (i_slot),
        .i_owner    (i_owner),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_kind     (o_kind),
        .o_slot_out (o_slot_out),
        .o_owner_out(o_owner_out),
        .o_last     (o_last)
    );

    always #2 i_clk = ~i_clk;

    function automatic void clear_watchdog_state();
        cfg_en      = 1'b0;
        cfg_timeout = TIMEOUT_RESET;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            free_slots[i] = SLOT_W'(i);
            beat_cnt[i]   = '0;
            beat_snap[i]  = '0;
            slot_owner[i] = '0;
            hang_seen[i]  = 1'b0;
            slot_used[i]  = 1'b0;
        end
        free_head = '0;
        free_cnt  = NUM_SLOTS;
        elapsed   = '0;
    endfunction

    function automatic void push_result(t_kind kind, logic [SLOT_W-1:0] slot,
                                        logic [OWNER_W-1:0] owner);
        t_result r;
        r.kind  = kind;
        r.slot  = slot;
        r.owner = owner;
        r.last  = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic int scan_for_hangs();
        int n;
        n = 0;
        for (int i = 0; i < NUM_SLOTS && n < MAX_RESULTS; i++) begin
            if (slot_owner[i] != '0 && !hang_seen[i]) begin
                if (beat_snap[i] == beat_cnt[i]) begin
                    hang_seen[i] = 1'b1;
                    push_result(KIND_HANG, SLOT_W'(i), slot_owner[i]);
                    n++;
                end
                beat_snap[i] = beat_cnt[i];
            end
        end
        return n;
    endfunction

    function automatic void advance_watchdog(t_op op, logic [SLOT_W-1:0] slot,
                                             logic [OWNER_W-1:0] owner);
        int                n;
        logic [SLOT_W-1:0] g;
        logic [SLOT_W-1:0] tail;
        logic [TICK_W-1:0] lim;
        t_result           r;
        n = 0;
        case (op)
            OP_REGISTER: begin
                if (free_cnt == 0) begin
                    push_result(KIND_REFUSED, '0, '0);
                end else begin
                    g = free_slots[free_head];
                    free_head = free_head + 1'b1;
                    free_cnt--;
                    beat_cnt[g]   = '0;
                    beat_snap[g]  = '0;
                    slot_owner[g] = owner;
                    hang_seen[g]  = 1'b0;
                    slot_used[g]  = 1'b1;
                    push_result(KIND_GRANTED, g, '0);
                end
                n = 1;
            end
            OP_HEARTBEAT, OP_RELEASE: begin
                if (!slot_used[slot]) begin
                    push_result(KIND_REFUSED, '0, '0);
                    n = 1;
                end else if (op == OP_HEARTBEAT) begin
                    beat_cnt[slot] = beat_cnt[slot] + 1;
                end else begin
                    tail = free_head + SLOT_W'(free_cnt);
                    slot_owner[slot] = '0;
                    slot_used[slot]  = 1'b0;
                    free_slots[tail] = slot;
                    free_cnt++;
                    push_result(KIND_RELEASED, slot, '0);
                    n = 1;
                end
            end
            default: begin
                if (!cfg_en) begin
                    elapsed = '0;
                end else begin
                    lim = (cfg_timeout == '0) ? TICK_W'(1) : cfg_timeout;
                    if (elapsed != '1)
                        elapsed = elapsed + 1;
                    if (elapsed >= lim) begin
                        elapsed = '0;
                        n = scan_for_hangs();
                    end
                end
            end
        endcase
        if (n > 0) begin
            r = pending_results.pop_back();
            r.last = 1'b1;
            pending_results.push_back(r);
        end
    endfunction

    function automatic logic [SLOT_W-1:0] pick_live_slot();
        logic [SLOT_W-1:0] live[$];
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_used[i])
                live.push_back(SLOT_W'(i));
        if (live.size() == 0)
            return SLOT_W'($urandom);
        return live[$urandom_range(live.size() - 1)];
    endfunction

    function automatic logic [OWNER_W-1:0] random_owner();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_cmd(t_op op, logic [SLOT_W-1:0] slot, logic [OWNER_W-1:0] owner,
                            int idle_pct);
        int gap;
        start       <= 1'b1;
        i_operation <= op;
        i_slot      <= slot;
        i_owner     <= owner;
        do @(posedge i_clk); while (busy !== 1'b0);
        advance_watchdog(op, slot, owner);
        gap = 0;
        while (idle_pct > 0 && gap < 24 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic settle();
        hold_until_drained();
        while (busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_ENABLE)
            cfg_en = data[0];
        else
            cfg_timeout = data;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_items(int count, int idle_pct);
        int                 pick;
        t_op                op;
        logic [SLOT_W-1:0]  slot;
        logic [OWNER_W-1:0] owner;
        for (int k = 0; k < count; k++) begin
            pick  = $urandom_range(99);
            slot  = SLOT_W'($urandom);
            owner = random_owner();
            if (pick < 15) begin
                op = OP_REGISTER;
            end else if (pick < 52) begin
                op   = OP_HEARTBEAT;
                slot = pick_live_slot();
            end else if (pick < 64) begin
                op   = OP_RELEASE;
                slot = pick_live_slot();
            end else if (pick < 90) begin
                op = OP_TICK;
            end else begin
                op = (pick < 95) ? OP_HEARTBEAT : OP_RELEASE;
            end
            if (k == count / 2)
                hold_until_drained();
            send_cmd(op, slot, owner, ((k % 40) < 8) ? 0 : idle_pct);
        end
    endtask

    task automatic test_basic_commands();
        send_cmd(OP_HEARTBEAT, 5'd0, '0, 17);
        send_cmd(OP_RELEASE, 5'd31, '1, 17);
        send_cmd(OP_TICK, 5'd31, '0, 17);
        send_cmd(OP_REGISTER, 5'd0, 32'hFFFF_FFFF, 17);
        send_cmd(OP_REGISTER, 5'd0, 32'h0000_0000, 17);
        send_cmd(OP_REGISTER, 5'd0, 32'hA5A5_5A5A, 17);
        send_cmd(OP_HEARTBEAT, 5'd0, '0, 0);
        send_cmd(OP_RELEASE, 5'd1, '0, 0);
        send_cmd(OP_RELEASE, 5'd1, '0, 0);
        send_cmd(OP_REGISTER, 5'd0, 32'h0000_0001, 0);
    endtask

    task automatic test_scan_rules();
        settle();
        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_TIMEOUT, 32'd1);
        send_cmd(OP_TICK, '0, '0, 17);
        send_cmd(OP_HEARTBEAT, 5'd2, '0, 17);
        send_cmd(OP_TICK, '0, '0, 17);
        send_cmd(OP_RELEASE, 5'd2, '0, 17);
        send_cmd(OP_TICK, '0, '0, 17);
        settle();
        write_reg(CFG_TIMEOUT, 32'd0);
        write_reg(CFG_ENABLE, 32'hFFFF_FFFF);
        send_cmd(OP_REGISTER, 5'd10, 32'h8000_0000, 0);
        send_cmd(OP_TICK, '0, '0, 0);
        settle();
        write_reg(CFG_ENABLE, 32'hFFFF_FFFE);
        send_cmd(OP_TICK, '0, '0, 0);
        send_cmd(OP_HEARTBEAT, 5'd21, '0, 0);
        settle();
        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        send_cmd(OP_TICK, '0, '0, 0);
        send_cmd(OP_TICK, '0, '0, 0);
    endtask

    task automatic test_queue_exhaustion();
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_used[i])
                send_cmd(OP_RELEASE, SLOT_W'(i), $urandom, 17);
        settle();
        write_reg(CFG_TIMEOUT, 32'd1);
        for (int i = 0; i <= NUM_SLOTS; i++)
            send_cmd(OP_REGISTER, SLOT_W'($urandom), $urandom | 32'd1, 17);
        send_cmd(OP_TICK, '0, '0, 0);
        send_cmd(OP_TICK, '0, '0, 0);
        for (int i = 0; i < NUM_SLOTS; i++)
            send_cmd(OP_RELEASE, SLOT_W'(i), '0, 0);
    endtask

    task automatic test_random_traffic();
        settle();
        write_reg(CFG_TIMEOUT, 32'd2);
        random_items(140, 17);
        settle();
        write_reg(CFG_TIMEOUT, 32'($urandom_range(1, 5)));
        random_items(140, 65);
        settle();
        write_reg(CFG_TIMEOUT, 32'd1);
        random_items(140, 0);
    endtask

    task automatic test_checking_disabled();
        settle();
        write_reg(CFG_ENABLE, $urandom & 32'hFFFF_FFFE);
        random_items(30, 17);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result exp_r;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d slot_out %0d", o_kind, o_slot_out);
                n_fail++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_kind !== exp_r.kind) begin
                    $error("kind: expected %0d, got %0d", exp_r.kind, o_kind);
                    n_fail++;
                end
                if (o_slot_out !== exp_r.slot) begin
                    $error("slot_out: expected %0d, got %0d", exp_r.slot, o_slot_out);
                    n_fail++;
                end
                if (o_owner_out !== exp_r.owner) begin
                    $error("owner_out: expected %08h, got %08h", exp_r.owner, o_owner_out);
                    n_fail++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, o_last);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        clear_watchdog_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_commands();
        test_scan_rules();
        test_queue_exhaustion();
        test_random_traffic();
        test_checking_disabled();
        settle();
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/mshw_pkg.sv
rtl/mshw_ctrl.sv
rtl/mshw_datapath.sv
rtl/multi_slot_heartbeat_watchdog_unit.sv
dv/tb_top.sv
